### sv/rlt_pkg.sv
package rlt_pkg;

   // Token kind codes.
   localparam logic [4:0] K_END      = 5'd0;
   localparam logic [4:0] K_STRING   = 5'd1;
   localparam logic [4:0] K_LPAREN   = 5'd2;
   localparam logic [4:0] K_RPAREN   = 5'd3;
   localparam logic [4:0] K_LBRACKET = 5'd4;
   localparam logic [4:0] K_RBRACKET = 5'd5;
   localparam logic [4:0] K_LE       = 5'd6;
   localparam logic [4:0] K_LARROW   = 5'd7;
   localparam logic [4:0] K_LT       = 5'd8;
   localparam logic [4:0] K_GE       = 5'd9;
   localparam logic [4:0] K_GT       = 5'd10;
   localparam logic [4:0] K_ADD      = 5'd11;
   localparam logic [4:0] K_SUB      = 5'd12;
   localparam logic [4:0] K_MUL      = 5'd13;
   localparam logic [4:0] K_DIV      = 5'd14;
   localparam logic [4:0] K_MOD      = 5'd15;
   localparam logic [4:0] K_EQ       = 5'd16;
   localparam logic [4:0] K_NE       = 5'd17;
   localparam logic [4:0] K_RELATION = 5'd18;
   localparam logic [4:0] K_STRATUM  = 5'd19;
   localparam logic [4:0] K_LET      = 5'd20;
   localparam logic [4:0] K_INT      = 5'd21;
   localparam logic [4:0] K_IDENT    = 5'd22;
   localparam logic [4:0] K_ERROR    = 5'd23;

   // Error codes.
   localparam logic [1:0] E_NONE       = 2'd0;
   localparam logic [1:0] E_UNEXPECTED = 2'd1;
   localparam logic [1:0] E_UNTERM     = 2'd2;

   // Keyword candidates.
   localparam logic [1:0] KW_NONE     = 2'd0;
   localparam logic [1:0] KW_RELATION = 2'd1;
   localparam logic [1:0] KW_STRATUM  = 2'd2;
   localparam logic [1:0] KW_LET      = 2'd3;

   localparam int FIELD_W     = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [4:0]         kind;
      logic [FIELD_W-1:0] start;
      logic [FIELD_W-1:0] len;
      logic               cmp;
      logic [1:0]         err;
   } token_type;

   // All tokens caused by one input item.
   typedef struct packed {
      logic [1:0]           count;
      token_type [2:0]      tok;
   } bundle_type;

   // Length of a keyword candidate.
   function automatic logic [3:0] kw_len(input logic [1:0] choice);
      case (choice)
         KW_RELATION: kw_len = 4'd8;
         KW_STRATUM:  kw_len = 4'd7;
         KW_LET:      kw_len = 4'd3;
         default:     kw_len = 4'd0;
      endcase
   endfunction

   // Character of a keyword candidate at a given offset.
   function automatic logic [7:0] kw_char(input logic [1:0] choice, input logic [3:0] p);
      logic [63:0] txt;
      txt = 64'h0;
      case (choice)
         KW_RELATION: txt = "relation";
         KW_STRATUM:  txt = {"stratum", 8'h00};
         KW_LET:      txt = {"let", 40'h0};
         default:     txt = 64'h0;
      endcase
      kw_char = txt[8'(63 - 8 * int'(p[2:0])) -: 8];
   endfunction

endpackage

### sv/rlt_if.sv
interface rlt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_marker;

   modport source (output valid, output char_code, output end_marker, input ready);
   modport sink (input valid, input char_code, input end_marker, output ready);
endinterface

interface rlt_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [15:0] start_pos;
   logic [15:0] token_len;
   logic        is_compare;
   logic [1:0]  error_code;
   logic        last_of_run;

   modport source (output valid, output token_kind, output start_pos, output token_len,
                   output is_compare, output error_code, output last_of_run, input ready);
   modport sink (input valid, input token_kind, input start_pos, input token_len,
                 input is_compare, input error_code, input last_of_run, output ready);
endinterface

### sv/rlt_scan.sv
module rlt_scan #(
   parameter int POS_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          char_code,
   input  logic                end_marker,
   output logic                push,
   output rlt_pkg::bundle_type bundle
);

   localparam logic [3:0] M_IDLE    = 4'd0;
   localparam logic [3:0] M_STRING  = 4'd1;
   localparam logic [3:0] M_LT      = 4'd2;
   localparam logic [3:0] M_LTDASH  = 4'd3;
   localparam logic [3:0] M_GT      = 4'd4;
   localparam logic [3:0] M_BANG    = 4'd5;
   localparam logic [3:0] M_EQ      = 4'd6;
   localparam logic [3:0] M_INT     = 4'd7;
   localparam logic [3:0] M_IDENT   = 4'd8;
   localparam logic [3:0] M_KEYWORD = 4'd9;

   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   logic [3:0]          mode_ff, mode_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [POS_BITS-1:0] begin_ff, begin_in;
   logic [3:0]          kprog_ff, kprog_in;
   logic [1:0]          kchoice_ff, kchoice_in;
   logic                ehold_ff, ehold_in;

   function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
      sat_inc = (v == POS_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [rlt_pkg::FIELD_W-1:0] low_bits(input logic [POS_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      low_bits = w[rlt_pkg::FIELD_W-1:0];
   endfunction

   function automatic rlt_pkg::token_type mk(input logic [4:0] kind,
                                             input logic [POS_BITS-1:0] s,
                                             input logic [POS_BITS-1:0] l,
                                             input logic [1:0] err);
      rlt_pkg::token_type t;
      t.kind  = kind;
      t.start = low_bits(s);
      t.len   = low_bits(l);
      t.cmp   = (kind == rlt_pkg::K_EQ) || (kind == rlt_pkg::K_NE) ||
                (kind == rlt_pkg::K_LT) || (kind == rlt_pkg::K_LE) ||
                (kind == rlt_pkg::K_GT) || (kind == rlt_pkg::K_GE);
      t.err   = err;
      mk = t;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_ident(input logic [7:0] c);
      is_ident = is_alpha(c) || is_digit(c) || (c == "_") || (c == "-") ||
                 (c == "@") || (c == "~");
   endfunction

   // Classify the character against the pending token and build the token bundle.
   always_comb begin
      logic [1:0]          n;
      logic                rescan;
      logic [POS_BITS-1:0] cur;
      logic [7:0]          c;
      logic [3:0]          klen;

      n          = 2'd0;
      rescan     = 1'b0;
      cur        = pos_ff;
      c          = char_code;
      klen       = rlt_pkg::kw_len(kchoice_ff);
      bundle.tok = '0;
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      begin_in   = begin_ff;
      kprog_in   = kprog_ff;
      kchoice_in = kchoice_ff;
      ehold_in   = ehold_ff;

      if (end_marker) begin
         if (!ehold_ff) begin
            case (mode_ff)
               M_STRING: begin
                  bundle.tok[n] = mk(rlt_pkg::K_ERROR, begin_ff, pos_ff - begin_ff,
                                     rlt_pkg::E_UNTERM);
                  n = n + 2'd1;
               end
               M_LT: begin
                  bundle.tok[n] = mk(rlt_pkg::K_LT, begin_ff, POS_BITS'(1), rlt_pkg::E_NONE);
                  n = n + 2'd1;
               end
               M_LTDASH: begin
                  bundle.tok[n] = mk(rlt_pkg::K_LT, begin_ff, POS_BITS'(1), rlt_pkg::E_NONE);
                  n = n + 2'd1;
                  bundle.tok[n] = mk(rlt_pkg::K_SUB, sat_inc(begin_ff), POS_BITS'(1),
                                     rlt_pkg::E_NONE);
                  n = n + 2'd1;
               end
               M_GT: begin
                  bundle.tok[n] = mk(rlt_pkg::K_GT, begin_ff, POS_BITS'(1), rlt_pkg::E_NONE);
                  n = n + 2'd1;
               end
               M_BANG, M_EQ: begin
                  bundle.tok[n] = mk(rlt_pkg::K_ERROR, begin_ff, POS_BITS'(1),
                                     rlt_pkg::E_UNEXPECTED);
                  n = n + 2'd1;
               end
               M_INT: begin
                  bundle.tok[n] = mk(rlt_pkg::K_INT, begin_ff, pos_ff - begin_ff,
                                     rlt_pkg::E_NONE);
                  n = n + 2'd1;
               end
               M_IDENT, M_KEYWORD: begin
                  bundle.tok[n] = mk(rlt_pkg::K_IDENT, begin_ff, pos_ff - begin_ff,
                                     rlt_pkg::E_NONE);
                  n = n + 2'd1;
               end
               default: begin
               end
            endcase
         end
         bundle.tok[n] = mk(rlt_pkg::K_END, pos_ff, '0, rlt_pkg::E_NONE);
         n = n + 2'd1;
         mode_in    = M_IDLE;
         pos_in     = '0;
         begin_in   = '0;
         kprog_in   = '0;
         kchoice_in = rlt_pkg::KW_NONE;
         ehold_in   = 1'b0;
      end else begin
         if (!ehold_ff) begin
            // Finish or extend the pending token.
            case (mode_ff)
               M_STRING: begin
                  if (c == "\"") begin
                     bundle.tok[n] = mk(rlt_pkg::K_STRING, begin_ff, cur - begin_ff,
                                        rlt_pkg::E_NONE);
                     n = n + 2'd1;
                     mode_in = M_IDLE;
                  end
               end
               M_LT: begin
                  if (c == "=") begin
                     bundle.tok[n] = mk(rlt_pkg::K_LE, begin_ff, POS_BITS'(2), rlt_pkg::E_NONE);
                     n = n + 2'd1;
                     mode_in = M_IDLE;
                  end else if (c == "-") begin
                     mode_in = M_LTDASH;
                  end else begin
                     bundle.tok[n] = mk(rlt_pkg::K_LT, begin_ff, POS_BITS'(1), rlt_pkg::E_NONE);
                     n = n + 2'd1;
                     rescan = 1'b1;
                  end
               end
               M_LTDASH: begin
                  if (c == "-") begin
                     bundle.tok[n] = mk(rlt_pkg::K_LARROW, begin_ff, POS_BITS'(3),
                                        rlt_pkg::E_NONE);
                     n = n + 2'd1;
                     mode_in = M_IDLE;
                  end else begin
                     bundle.tok[n] = mk(rlt_pkg::K_LT, begin_ff, POS_BITS'(1), rlt_pkg::E_NONE);
                     n = n + 2'd1;
                     bundle.tok[n] = mk(rlt_pkg::K_SUB, sat_inc(begin_ff), POS_BITS'(1),
                                        rlt_pkg::E_NONE);
                     n = n + 2'd1;
                     rescan = 1'b1;
                  end
               end
               M_GT: begin
                  if (c == "=") begin
                     bundle.tok[n] = mk(rlt_pkg::K_GE, begin_ff, POS_BITS'(2), rlt_pkg::E_NONE);
                     n = n + 2'd1;
                     mode_in = M_IDLE;
                  end else begin
                     bundle.tok[n] = mk(rlt_pkg::K_GT, begin_ff, POS_BITS'(1), rlt_pkg::E_NONE);
                     n = n + 2'd1;
                     rescan = 1'b1;
                  end
               end
               M_BANG, M_EQ: begin
                  if (c == "=") begin
                     bundle.tok[n] = mk((mode_ff == M_EQ) ? rlt_pkg::K_EQ : rlt_pkg::K_NE,
                                        begin_ff, POS_BITS'(2), rlt_pkg::E_NONE);
                  end else begin
                     bundle.tok[n] = mk(rlt_pkg::K_ERROR, begin_ff, POS_BITS'(1),
                                        rlt_pkg::E_UNEXPECTED);
                     ehold_in = 1'b1;
                  end
                  n = n + 2'd1;
                  mode_in = M_IDLE;
               end
               M_INT: begin
                  if (!is_digit(c)) begin
                     bundle.tok[n] = mk(rlt_pkg::K_INT, begin_ff, cur - begin_ff,
                                        rlt_pkg::E_NONE);
                     n = n + 2'd1;
                     rescan = 1'b1;
                  end
               end
               M_KEYWORD: begin
                  if ((kchoice_ff != rlt_pkg::KW_NONE) && (kprog_ff < klen) &&
                      (c == rlt_pkg::kw_char(kchoice_ff, kprog_ff))) begin
                     kprog_in = kprog_ff + 4'd1;
                     if (kprog_ff + 4'd1 >= klen) begin
                        bundle.tok[n] = mk(rlt_pkg::K_RELATION + 5'(kchoice_ff) - 5'd1,
                                           begin_ff, POS_BITS'(klen), rlt_pkg::E_NONE);
                        n = n + 2'd1;
                        mode_in    = M_IDLE;
                        kprog_in   = '0;
                        kchoice_in = rlt_pkg::KW_NONE;
                     end
                  end else begin
                     kprog_in   = '0;
                     kchoice_in = rlt_pkg::KW_NONE;
                     mode_in    = M_IDENT;
                     if (!is_ident(c)) begin
                        bundle.tok[n] = mk(rlt_pkg::K_IDENT, begin_ff, cur - begin_ff,
                                           rlt_pkg::E_NONE);
                        n = n + 2'd1;
                        rescan = 1'b1;
                     end
                  end
               end
               M_IDENT: begin
                  if (!is_ident(c)) begin
                     bundle.tok[n] = mk(rlt_pkg::K_IDENT, begin_ff, cur - begin_ff,
                                        rlt_pkg::E_NONE);
                     n = n + 2'd1;
                     rescan = 1'b1;
                  end
               end
               default: rescan = 1'b1;
            endcase

            // Start a new token at this character.
            if (rescan) begin
               mode_in  = M_IDLE;
               begin_in = cur;
               case (c)
                  " ", "\t", "\n", "\r": begin
                  end
                  "\"": mode_in = M_STRING;
                  "(", ")", "[", "]", "+", "-", "*", "/", "%": begin
                     case (c)
                        "(":     bundle.tok[n] = mk(rlt_pkg::K_LPAREN, cur, POS_BITS'(1),
                                                    rlt_pkg::E_NONE);
                        ")":     bundle.tok[n] = mk(rlt_pkg::K_RPAREN, cur, POS_BITS'(1),
                                                    rlt_pkg::E_NONE);
                        "[":     bundle.tok[n] = mk(rlt_pkg::K_LBRACKET, cur, POS_BITS'(1),
                                                    rlt_pkg::E_NONE);
                        "]":     bundle.tok[n] = mk(rlt_pkg::K_RBRACKET, cur, POS_BITS'(1),
                                                    rlt_pkg::E_NONE);
                        "+":     bundle.tok[n] = mk(rlt_pkg::K_ADD, cur, POS_BITS'(1),
                                                    rlt_pkg::E_NONE);
                        "-":     bundle.tok[n] = mk(rlt_pkg::K_SUB, cur, POS_BITS'(1),
                                                    rlt_pkg::E_NONE);
                        "*":     bundle.tok[n] = mk(rlt_pkg::K_MUL, cur, POS_BITS'(1),
                                                    rlt_pkg::E_NONE);
                        "/":     bundle.tok[n] = mk(rlt_pkg::K_DIV, cur, POS_BITS'(1),
                                                    rlt_pkg::E_NONE);
                        default: bundle.tok[n] = mk(rlt_pkg::K_MOD, cur, POS_BITS'(1),
                                                    rlt_pkg::E_NONE);
                     endcase
                     n = n + 2'd1;
                  end
                  "<": mode_in = M_LT;
                  ">": mode_in = M_GT;
                  "!": mode_in = M_BANG;
                  "=": mode_in = M_EQ;
                  "r", "s", "l": begin
                     kchoice_in = (c == "r") ? rlt_pkg::KW_RELATION :
                                  (c == "s") ? rlt_pkg::KW_STRATUM : rlt_pkg::KW_LET;
                     kprog_in   = 4'd1;
                     mode_in    = M_KEYWORD;
                  end
                  default: begin
                     if (is_digit(c)) begin
                        mode_in = M_INT;
                     end else if (is_alpha(c) || (c == "@")) begin
                        mode_in = M_IDENT;
                     end else begin
                        bundle.tok[n] = mk(rlt_pkg::K_ERROR, cur, POS_BITS'(1),
                                           rlt_pkg::E_UNEXPECTED);
                        n = n + 2'd1;
                        ehold_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         pos_in = sat_inc(pos_ff);
      end
      bundle.count = n;
   end

   assign push = take && (bundle.count != 2'd0);

   // Scanner state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= M_IDLE;
         pos_ff     <= '0;
         begin_ff   <= '0;
         kprog_ff   <= '0;
         kchoice_ff <= rlt_pkg::KW_NONE;
         ehold_ff   <= 1'b0;
      end else if (take) begin
         mode_ff    <= mode_in;
         pos_ff     <= pos_in;
         begin_ff   <= begin_in;
         kprog_ff   <= kprog_in;
         kchoice_ff <= kchoice_in;
         ehold_ff   <= ehold_in;
      end
   end

endmodule

### sv/rlt_queue.sv
module rlt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rlt_pkg::bundle_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output rlt_pkg::bundle_type head
);

   rlt_pkg::bundle_type              mem [rlt_pkg::QUEUE_DEPTH];
   logic [rlt_pkg::QPTR_W-1:0]       wr_ff, wr_in;
   logic [rlt_pkg::QPTR_W-1:0]       rd_ff, rd_in;
   logic [rlt_pkg::QPTR_W:0]         cnt_ff, cnt_in;

   assign full      = (cnt_ff == (rlt_pkg::QPTR_W + 1)'(rlt_pkg::QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (rlt_pkg::QPTR_W + 1)'(push) - (rlt_pkg::QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Bundle storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

endmodule

### sv/rlt_emit.sv
module rlt_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                have,
   input  rlt_pkg::bundle_type head,
   output logic                pop,
   rlt_rsp_if.source           rsp
);

   logic [1:0]         idx_ff, idx_in;
   logic               last;
   rlt_pkg::token_type tok;

   assign tok  = head.tok[idx_ff];
   assign last = (idx_ff == head.count - 2'd1);

   // Present the current token of the head bundle.
   assign rsp.valid       = have;
   assign rsp.token_kind  = tok.kind;
   assign rsp.start_pos   = tok.start;
   assign rsp.token_len   = tok.len;
   assign rsp.is_compare  = tok.cmp;
   assign rsp.error_code  = tok.err;
   assign rsp.last_of_run = last;

   assign pop = have && rsp.ready && last;

   // Step through the bundle one item at a time.
   always_comb begin
      idx_in = idx_ff;
      if (have && rsp.ready) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

### sv/rule_language_tokenizer.sv
// Rule-language tokenizer.
// The req channel carries one character byte per item, or an end marker that
// closes the stream. The rsp channel carries tokens: kind, start position,
// length, comparison flag, error code and a flag on the last token that one
// input item caused (zero to three tokens per item).
// Throughput: one input item per cycle while the queue is not full. The
// scanner classifies each byte combinationally and places all of its tokens
// as one bundle in a four-entry queue; the emitter sends one token per cycle
// from the queue head while the receiver is ready. Each bundle is registered
// in the queue before the emitter presents its first token.
// Tokens that need lookahead (<, <-, >, =, !, numbers, names) come out with
// the following item or the end marker.
// Reset clears the scanner state, position counter and queue at once; no
// clearing pass is needed. When the receiver stalls, the current token holds
// and the queue fills; req ready drops only when all four entries are in use.
module rule_language_tokenizer #(
   parameter int POS_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   rlt_req_if.sink   req_if,
   rlt_rsp_if.source rsp_if
);

   logic                take;
   logic                push;
   logic                pop;
   logic                full;
   logic                have;
   rlt_pkg::bundle_type bundle;
   rlt_pkg::bundle_type head;

   assign req_if.ready = !full;
   assign take         = req_if.valid && !full;

   rlt_scan #(.POS_BITS(POS_BITS)) u_scan (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .char_code  (req_if.char_code),
      .end_marker (req_if.end_marker),
      .push       (push),
      .bundle     (bundle)
   );

   rlt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (bundle),
      .pop       (pop),
      .full      (full),
      .not_empty (have),
      .head      (head)
   );

   rlt_emit u_emit (
      .clock (clock),
      .reset (reset),
      .have  (have),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_if)
   );

endmodule

### sv/rlt_checker.sv
module rlt_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [4:0] rsp_kind,
   input logic       rsp_cmp,
   input logic [1:0] rsp_err,
   input logic       rsp_last
);

   // A stalled result keeps its kind.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("rsp item changed while stalled");

   // Nothing is presented right after reset.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // The end token always closes its run.
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == rlt_pkg::K_END) |-> rsp_last)
      else $error("end token not last of run");

   // Only error tokens carry an error code.
   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_err != rlt_pkg::E_NONE) |-> (rsp_kind == rlt_pkg::K_ERROR))
      else $error("error code on non-error token");

   // The compare flag matches the comparison kinds.
   a_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cmp == ((rsp_kind == rlt_pkg::K_EQ) || (rsp_kind == rlt_pkg::K_NE) ||
                                 (rsp_kind == rlt_pkg::K_LT) || (rsp_kind == rlt_pkg::K_LE) ||
                                 (rsp_kind == rlt_pkg::K_GT) || (rsp_kind == rlt_pkg::K_GE))))
      else $error("compare flag mismatch");

endmodule

bind rule_language_tokenizer rlt_checker u_rlt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_kind  (rsp_if.token_kind),
   .rsp_cmp   (rsp_if.is_compare),
   .rsp_err   (rsp_if.error_code),
   .rsp_last  (rsp_if.last_of_run)
);

### tb/tb_channels.sv
`timescale 1ns / 1ps

// Testbench-side view of the two channels; the block's own interfaces are used.
// This file only carries a small helper type shared by the testbench.
package tb_token_pkg;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [15:0] len;
      logic        cmp;
      logic [1:0]  err;
      logic        last;
   } token_rec_type;
endpackage

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int  POS_MAX      = 16'hFFFF;
   localparam int  CYCLE_LIMIT  = 400000;
   localparam int  RANDOM_ITEMS = 140;

   // Scanner modes of the predictor.
   typedef enum logic [3:0] {
      SM_IDLE, SM_STRING, SM_LT, SM_LTDASH, SM_GT, SM_BANG, SM_EQ, SM_INT,
      SM_IDENT, SM_KEYWORD
   } scan_mode_type;

   logic clock;
   logic reset;

   rlt_req_if req_if ();
   rlt_rsp_if rsp_if ();

   rule_language_tokenizer #(.POS_BITS(16)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #6;
      clock = 1'b1;
      #6;
      clock = 1'b0;
   end

   // Predictor state.
   scan_mode_type mode;
   logic [15:0]   pos;
   logic [15:0]   tok_begin;
   logic [3:0]    kw_progress;
   logic [1:0]    kw_choice;
   logic          err_hold;

   tb_token_pkg::token_rec_type expected_tokens[$];
   tb_token_pkg::token_rec_type step_tokens[$];
   int                          fail_count;
   int                          cycle_count;
   int                          rsp_wait;

   // One directed row: a character, optionally with a typed-in token.
   typedef struct {
      logic [7:0]                  ch;
      logic                        eom;
      int                          n_typed;
      tb_token_pkg::token_rec_type typed;
   } dir_row_type;

   function automatic logic [15:0] sat_inc(logic [15:0] v);
      return (v == POS_MAX) ? v : v + 16'd1;
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_name_char(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "_" || c == "-" || c == "@" || c == "~";
   endfunction

   function automatic logic [7:0] keyword_char(logic [1:0] ch, logic [3:0] p);
      string s;
      case (ch)
         rlt_pkg::KW_RELATION: s = "relation";
         rlt_pkg::KW_STRATUM:  s = "stratum";
         rlt_pkg::KW_LET:      s = "let";
         default:              s = "";
      endcase
      return (p < s.len()) ? s[p] : 8'h00;
   endfunction

   function automatic logic [3:0] keyword_length(logic [1:0] ch);
      case (ch)
         rlt_pkg::KW_RELATION: return 4'd8;
         rlt_pkg::KW_STRATUM:  return 4'd7;
         rlt_pkg::KW_LET:      return 4'd3;
         default:              return 4'd0;
      endcase
   endfunction

   task automatic push_token(logic [4:0] kind, logic [15:0] start, logic [15:0] len,
                             logic [1:0] err);
      tb_token_pkg::token_rec_type t;
      if (step_tokens.size() >= 3) return;
      t.kind  = kind;
      t.start = start;
      t.len   = len;
      t.cmp   = kind inside {rlt_pkg::K_EQ, rlt_pkg::K_NE, rlt_pkg::K_LT, rlt_pkg::K_LE,
                             rlt_pkg::K_GT, rlt_pkg::K_GE};
      t.err   = err;
      t.last  = 1'b0;
      step_tokens.push_back(t);
   endtask

   task automatic flag_error(logic [15:0] at);
      push_token(rlt_pkg::K_ERROR, at, 16'd1, rlt_pkg::E_UNEXPECTED);
      err_hold = 1'b1;
      mode     = SM_IDLE;
   endtask

   // Scan a character starting from the between-tokens state.
   task automatic start_token(logic [7:0] c, logic [15:0] cur);
      mode      = SM_IDLE;
      tok_begin = cur;
      if (c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D) return;
      case (c)
         "\"": mode = SM_STRING;
         "(": push_token(rlt_pkg::K_LPAREN, cur, 16'd1, rlt_pkg::E_NONE);
         ")": push_token(rlt_pkg::K_RPAREN, cur, 16'd1, rlt_pkg::E_NONE);
         "[": push_token(rlt_pkg::K_LBRACKET, cur, 16'd1, rlt_pkg::E_NONE);
         "]": push_token(rlt_pkg::K_RBRACKET, cur, 16'd1, rlt_pkg::E_NONE);
         "+": push_token(rlt_pkg::K_ADD, cur, 16'd1, rlt_pkg::E_NONE);
         "-": push_token(rlt_pkg::K_SUB, cur, 16'd1, rlt_pkg::E_NONE);
         "*": push_token(rlt_pkg::K_MUL, cur, 16'd1, rlt_pkg::E_NONE);
         "/": push_token(rlt_pkg::K_DIV, cur, 16'd1, rlt_pkg::E_NONE);
         "%": push_token(rlt_pkg::K_MOD, cur, 16'd1, rlt_pkg::E_NONE);
         "<": mode = SM_LT;
         ">": mode = SM_GT;
         "!": mode = SM_BANG;
         "=": mode = SM_EQ;
         "r": begin
            kw_choice = rlt_pkg::KW_RELATION; kw_progress = 4'd1; mode = SM_KEYWORD;
         end
         "s": begin
            kw_choice = rlt_pkg::KW_STRATUM; kw_progress = 4'd1; mode = SM_KEYWORD;
         end
         "l": begin
            kw_choice = rlt_pkg::KW_LET; kw_progress = 4'd1; mode = SM_KEYWORD;
         end
         default: begin
            if (is_digit(c)) mode = SM_INT;
            else if (is_alpha(c) || c == "@") mode = SM_IDENT;
            else flag_error(cur);
         end
      endcase
   endtask

   // Returns 1 when the character is consumed by the pending token.
   task automatic continue_token(logic [7:0] c, logic [15:0] cur, output bit consumed);
      consumed = 1'b1;
      case (mode)
         SM_STRING: begin
            if (c == "\"") begin
               push_token(rlt_pkg::K_STRING, tok_begin, cur - tok_begin, rlt_pkg::E_NONE);
               mode = SM_IDLE;
            end
         end
         SM_LT: begin
            if (c == "=") begin
               push_token(rlt_pkg::K_LE, tok_begin, 16'd2, rlt_pkg::E_NONE);
               mode = SM_IDLE;
            end else if (c == "-") begin
               mode = SM_LTDASH;
            end else begin
               push_token(rlt_pkg::K_LT, tok_begin, 16'd1, rlt_pkg::E_NONE);
               consumed = 1'b0;
            end
         end
         SM_LTDASH: begin
            if (c == "-") begin
               push_token(rlt_pkg::K_LARROW, tok_begin, 16'd3, rlt_pkg::E_NONE);
               mode = SM_IDLE;
            end else begin
               push_token(rlt_pkg::K_LT, tok_begin, 16'd1, rlt_pkg::E_NONE);
               push_token(rlt_pkg::K_SUB, sat_inc(tok_begin), 16'd1, rlt_pkg::E_NONE);
               consumed = 1'b0;
            end
         end
         SM_GT: begin
            if (c == "=") begin
               push_token(rlt_pkg::K_GE, tok_begin, 16'd2, rlt_pkg::E_NONE);
               mode = SM_IDLE;
            end else begin
               push_token(rlt_pkg::K_GT, tok_begin, 16'd1, rlt_pkg::E_NONE);
               consumed = 1'b0;
            end
         end
         SM_BANG, SM_EQ: begin
            if (c == "=") begin
               push_token((mode == SM_EQ) ? rlt_pkg::K_EQ : rlt_pkg::K_NE, tok_begin, 16'd2,
                          rlt_pkg::E_NONE);
               mode = SM_IDLE;
            end else begin
               flag_error(tok_begin);
            end
         end
         SM_INT: begin
            if (!is_digit(c)) begin
               push_token(rlt_pkg::K_INT, tok_begin, cur - tok_begin, rlt_pkg::E_NONE);
               consumed = 1'b0;
            end
         end
         SM_KEYWORD: begin
            if (kw_choice != rlt_pkg::KW_NONE && kw_progress < keyword_length(kw_choice) &&
                c == keyword_char(kw_choice, kw_progress)) begin
               kw_progress = kw_progress + 4'd1;
               if (kw_progress >= keyword_length(kw_choice)) begin
                  push_token(rlt_pkg::K_RELATION + 5'(kw_choice) - 5'd1, tok_begin,
                             16'(keyword_length(kw_choice)), rlt_pkg::E_NONE);
                  mode        = SM_IDLE;
                  kw_progress = 4'd0;
                  kw_choice   = rlt_pkg::KW_NONE;
               end
            end else begin
               kw_progress = 4'd0;
               kw_choice   = rlt_pkg::KW_NONE;
               mode        = SM_IDENT;
               if (!is_name_char(c)) begin
                  push_token(rlt_pkg::K_IDENT, tok_begin, cur - tok_begin, rlt_pkg::E_NONE);
                  consumed = 1'b0;
               end
            end
         end
         SM_IDENT: begin
            if (!is_name_char(c)) begin
               push_token(rlt_pkg::K_IDENT, tok_begin, cur - tok_begin, rlt_pkg::E_NONE);
               consumed = 1'b0;
            end
         end
         default: consumed = 1'b0;
      endcase
   endtask

   // Tokens still pending when the end marker arrives.
   task automatic flush_pending();
      case (mode)
         SM_STRING: push_token(rlt_pkg::K_ERROR, tok_begin, pos - tok_begin,
                               rlt_pkg::E_UNTERM);
         SM_LT:     push_token(rlt_pkg::K_LT, tok_begin, 16'd1, rlt_pkg::E_NONE);
         SM_LTDASH: begin
            push_token(rlt_pkg::K_LT, tok_begin, 16'd1, rlt_pkg::E_NONE);
            push_token(rlt_pkg::K_SUB, sat_inc(tok_begin), 16'd1, rlt_pkg::E_NONE);
         end
         SM_GT:     push_token(rlt_pkg::K_GT, tok_begin, 16'd1, rlt_pkg::E_NONE);
         SM_BANG, SM_EQ: push_token(rlt_pkg::K_ERROR, tok_begin, 16'd1,
                                    rlt_pkg::E_UNEXPECTED);
         SM_INT:    push_token(rlt_pkg::K_INT, tok_begin, pos - tok_begin, rlt_pkg::E_NONE);
         SM_IDENT, SM_KEYWORD: push_token(rlt_pkg::K_IDENT, tok_begin, pos - tok_begin,
                                          rlt_pkg::E_NONE);
         default: ;
      endcase
   endtask

   task automatic clear_scanner();
      mode        = SM_IDLE;
      pos         = 16'd0;
      tok_begin   = 16'd0;
      kw_progress = 4'd0;
      kw_choice   = rlt_pkg::KW_NONE;
      err_hold    = 1'b0;
   endtask

   // Works out the tokens of one accepted item and queues them as expected.
   task automatic predict_tokens(logic [7:0] c, logic eom);
      bit consumed;
      step_tokens.delete();
      if (eom) begin
         if (!err_hold) flush_pending();
         push_token(rlt_pkg::K_END, pos, 16'd0, rlt_pkg::E_NONE);
         clear_scanner();
      end else begin
         if (!err_hold) begin
            continue_token(c, pos, consumed);
            if (!consumed) start_token(c, pos);
         end
         pos = sat_inc(pos);
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endtask

   // Drives one item and waits until it is accepted. Valid stays high after
   // acceptance so that the next item can follow with no gap.
   task automatic send_item(logic [7:0] c, logic eom);
      int gap;
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.char_code  <= c;
      req_if.end_marker <= eom;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_tokens(c, eom);
   endtask

   // Drops valid after the last item of a burst.
   task automatic idle_req();
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: a drawn wait before each item, compare with the oldest expectation.
   always @(posedge clock) begin
      tb_token_pkg::token_rec_type exp_tok;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_tokens.size() == 0) begin
               $error("token with no expectation: kind %0d", rsp_if.token_kind);
               fail_count++;
            end else begin
               exp_tok = expected_tokens.pop_front();
               if (rsp_if.token_kind !== exp_tok.kind) begin
                  $error("token_kind expected %0d got %0d", exp_tok.kind, rsp_if.token_kind);
                  fail_count++;
               end
               if (rsp_if.start_pos !== exp_tok.start) begin
                  $error("start_pos expected %0d got %0d", exp_tok.start, rsp_if.start_pos);
                  fail_count++;
               end
               if (rsp_if.token_len !== exp_tok.len) begin
                  $error("token_len expected %0d got %0d", exp_tok.len, rsp_if.token_len);
                  fail_count++;
               end
               if (rsp_if.is_compare !== exp_tok.cmp) begin
                  $error("is_compare expected %0d got %0d", exp_tok.cmp, rsp_if.is_compare);
                  fail_count++;
               end
               if (rsp_if.error_code !== exp_tok.err) begin
                  $error("error_code expected %0d got %0d", exp_tok.err, rsp_if.error_code);
                  fail_count++;
               end
               if (rsp_if.last_of_run !== exp_tok.last) begin
                  $error("last_of_run expected %0d got %0d", exp_tok.last,
                         rsp_if.last_of_run);
                  fail_count++;
               end
            end
            rsp_wait = $urandom_range(0, 10);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_if.ready <= (rsp_wait == 0);
      end
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // Sends a text followed by the end marker.
   task automatic send_text(string s);
      foreach (s[i]) send_item(s[i], 1'b0);
      send_item(8'h00, 1'b1);
   endtask

   // Random character, biased toward characters that start or continue tokens.
   function automatic logic [7:0] pick_char();
      string alphabet;
      alphabet = "relationstratumlet()[]+-*/%<>=!\"  \t\n09az_@~-Zx";
      if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
      return alphabet[$urandom_range(0, alphabet.len() - 1)];
   endfunction

   // Random well-formed-ish stream of fragments.
   task automatic send_random_stream(inout int sent);
      string frags[$];
      int    n;
      frags = '{"relation", "stratum", "let", "letter", "rel", "str", "x_1", "@a~b",
                "123", "0", "\"ab c\"", "\"\"", "<", "<=", "<--", "<-x", ">", ">=",
                "==", "!=", "(", ")", "[", "]", "+", "-", "*", "/", "%", " ", "\t",
                "\n", "\r", "a<b", "9z"};
      n = $urandom_range(1, 12);
      repeat (n) begin
         string f;
         if ($urandom_range(0, 9) == 0) begin
            send_item(pick_char(), 1'b0);
            sent++;
         end else begin
            f = frags[$urandom_range(0, frags.size() - 1)];
            foreach (f[i]) begin
               send_item(f[i], 1'b0);
               sent++;
            end
         end
         if ($urandom_range(0, 1) == 0) begin
            send_item(" ", 1'b0);
            sent++;
         end
      end
      send_item(8'($urandom_range(0, 255)), 1'b1);
      sent++;
   endtask

   dir_row_type directed[$];

   function automatic tb_token_pkg::token_rec_type mk(logic [4:0] k, logic [15:0] s,
                                                      logic [15:0] l, logic [1:0] e);
      tb_token_pkg::token_rec_type t;
      t.kind  = k;
      t.start = s;
      t.len   = l;
      t.cmp   = 1'b0;
      t.err   = e;
      t.last  = 1'b1;
      return t;
   endfunction

   initial begin
      int                          sent;
      int                          drain;
      tb_token_pkg::token_rec_type want;
      fail_count   = 0;
      cycle_count  = 0;
      rsp_wait     = 0;
      clock        = 1'b0;
      reset        = 1'b1;
      req_if.valid      = 1'b0;
      req_if.char_code  = 8'h00;
      req_if.end_marker = 1'b0;
      rsp_if.ready      = 1'b0;
      clear_scanner();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: end marker after reset, extremes, bad characters.
      directed = '{
         '{8'h00, 1'b1, 1, mk(rlt_pkg::K_END, 16'd0, 16'd0, rlt_pkg::E_NONE)},
         '{8'hFF, 1'b0, 1, mk(rlt_pkg::K_ERROR, 16'd0, 16'd1, rlt_pkg::E_UNEXPECTED)},
         '{8'h00, 1'b0, 0, mk(rlt_pkg::K_END, 16'd0, 16'd0, rlt_pkg::E_NONE)},
         '{8'hFF, 1'b1, 1, mk(rlt_pkg::K_END, 16'd2, 16'd0, rlt_pkg::E_NONE)},
         '{"(", 1'b0, 1, mk(rlt_pkg::K_LPAREN, 16'd0, 16'd1, rlt_pkg::E_NONE)},
         '{"#", 1'b0, 1, mk(rlt_pkg::K_ERROR, 16'd1, 16'd1, rlt_pkg::E_UNEXPECTED)},
         '{"(", 1'b0, 0, mk(rlt_pkg::K_END, 16'd0, 16'd0, rlt_pkg::E_NONE)},
         '{8'h00, 1'b1, 1, mk(rlt_pkg::K_END, 16'd3, 16'd0, rlt_pkg::E_NONE)},
         '{"=", 1'b0, 0, mk(rlt_pkg::K_END, 16'd0, 16'd0, rlt_pkg::E_NONE)},
         '{"x", 1'b0, 1, mk(rlt_pkg::K_ERROR, 16'd0, 16'd1, rlt_pkg::E_UNEXPECTED)},
         '{8'h00, 1'b1, 1, mk(rlt_pkg::K_END, 16'd2, 16'd0, rlt_pkg::E_NONE)}
      };
      foreach (directed[i]) begin
         send_item(directed[i].ch, directed[i].eom);
         if (directed[i].n_typed == 1) begin
            want = directed[i].typed;
            if (expected_tokens.size() == 0 || expected_tokens[$] !== want) begin
               $error("directed row %0d: predictor disagrees with typed token", i);
               fail_count++;
            end
         end
      end

      // Every operator, the keywords, strings, and the lookahead cases.
      send_text(" \"str ing\"()[]+-*/%<= <-- < > >= == != 42 abc_@~- letter stratum");
      send_text("relation rel<-x <- l");
      send_text("\"open string");
      send_text("!x ignored");
      send_text("< ");
      send_text("<-");
      send_text("=");

      // Let every queued token drain before carrying on.
      idle_req();
      while (expected_tokens.size() != 0) @(posedge clock);

      // Random streams of fragments with noise.
      sent = 0;
      while (sent < RANDOM_ITEMS) send_random_stream(sent);

      idle_req();
      while (expected_tokens.size() != 0) @(posedge clock);
      drain = 0;
      while (drain < 20) begin
         @(posedge clock);
         drain++;
      end
      if (fail_count == 0 && expected_tokens.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
